>>> hdl/saa_pkg.sv
package saa_pkg;

  // Candidate store geometry
  localparam int MaxCandidates = 64;
  localparam int CandAw        = $clog2(MaxCandidates);
  localparam int CntW          = CandAw + 1;

  // Result cap
  localparam int MaxLights   = 32;
  localparam int ResultLimit = 32;
  localparam int EmitCap     = (MaxLights < ResultLimit) ? MaxLights : ResultLimit;
  localparam int EmitW       = $clog2(EmitCap + 1);

  // Atlas dimension register reset and index codes
  localparam logic [8:0] DimReset  = 9'd16;
  localparam logic       RegWidth  = 1'b0;
  localparam logic       RegHeight = 1'b1;

  typedef struct packed {
    logic [5:0]  light_id;
    logic        visible;
    logic [15:0] light_priority;
    logic [4:0]  size_blocks;
    logic        last;
  } in_t;

  typedef struct packed {
    logic [5:0] light_id_res;
    logic [7:0] atlas_x;
    logic [7:0] atlas_y;
    logic [4:0] side_blocks;
    logic       last_res;
  } out_t;

  // One store entry
  typedef struct packed {
    logic [5:0]  id;
    logic        vis;
    logic [15:0] prio;
    logic [4:0]  side;
  } cand_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic sel_init;
    logic scan_clr;
    logic scan_run;
    logic mode_emit;
    logic admit;
    logic emit_init;
    logic emit_out;
    logic dflt_out;
    logic finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;
    logic best_vld;
    logic fits;
    logic any_sel;
    logic admit_zero;
    logic emit_last;
    logic out_free;
  } status_t;

endpackage

>>> hdl/shadow_atlas_allocator_unit.sv
// Shadow atlas allocator. Candidates are loaded at one per cycle into a
// 64-entry store; the item marked last starts allocation and the input stalls
// until the run's results have all been handed over. Allocation rescans the
// store through its single read port; each pass reads every stored entry,
// drains the read register and then takes a decision. With A admitted and E
// emitted lights (E is A capped at 32), there are A + 1 selection passes and
// E emission passes; output stalls hold up emission.
// Atlas width and height are written through the plain write port; the user
// must write them only while the block is idle, which the block does not enforce.
module shadow_atlas_allocator_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [8:0]     cfg_wdata_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  saa_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output saa_pkg::out_t  out_data_o
);
  import saa_pkg::*;

  cmd_t    cmd;
  status_t status;

  saa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_data_i.last),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  saa_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef NO_ASSERTIONS
  // A placement always has a selected light behind it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit_out |-> status.best_vld) else $error("emit without selection");

  // A pending result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_out || cmd.dflt_out) |-> status.out_free) else $error("result overwritten");

  // Input is held off once allocation starts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.sel_init |=> in_stall_o) else $error("input open during allocation");
`endif

endmodule

>>> hdl/saa_datapath.sv
module saa_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [8:0]       cfg_wdata_i,
  input  saa_pkg::in_t     in_data_i,
  input  saa_pkg::cmd_t    cmd_i,
  output saa_pkg::status_t status_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output saa_pkg::out_t    out_data_o
);
  import saa_pkg::*;

  cand_t             mem [MaxCandidates];
  cand_t             rd_data_q;
  logic [CandAw-1:0] rd_idx_q;
  logic              rd_vld_q;
  logic [CntW-1:0]   scan_q;
  logic [CntW-1:0]   cnt_q;
  logic [5:0]        first_q;
  logic [8:0]        width_q, height_q;
  logic [MaxCandidates-1:0] flag_q;

  logic              best_vld_q;
  logic [CandAw-1:0] best_idx_q;
  logic [5:0]        best_id_q;
  logic [15:0]       best_prio_q;
  logic [4:0]        best_side_q;

  logic              prev_vld_q;
  logic [CandAw-1:0] prev_idx_q;
  logic [15:0]       prev_prio_q;
  logic [4:0]        prev_side_q;

  logic [16:0]       total_q, budget_q, zidx_q;
  logic [CntW-1:0]   admit_q;
  logic [EmitW-1:0]  emit_q;
  logic              out_vld_q;
  out_t              out_q;

  logic              rd_en, qual, better, after_p, after_e, emit_last;
  logic [9:0]        sq;
  logic [16:0]       total_sum;
  logic [8:0]        w_c, h_c;
  logic [17:0]       prod;
  logic [CntW-1:0]   emitted;
  cand_t             wr_c;

  // Store write and scan read
  assign rd_en = cmd_i.scan_run && (scan_q < cnt_q);

  always_comb begin
    wr_c.id   = in_data_i.light_id;
    wr_c.vis  = in_data_i.visible;
    wr_c.prio = in_data_i.light_priority;
    wr_c.side = (in_data_i.size_blocks == 5'd0) ? 5'd1 : in_data_i.size_blocks;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (cnt_q < CntW'(MaxCandidates))) begin
      mem[cnt_q[CandAw-1:0]] <= wr_c;
    end
    if (rd_en) begin
      rd_data_q <= mem[scan_q[CandAw-1:0]];
      rd_idx_q  <= scan_q[CandAw-1:0];
    end
  end

  // Ordering tests against the previous pick and the running best
  always_comb begin
    after_p = (rd_data_q.prio < prev_prio_q) ||
              ((rd_data_q.prio == prev_prio_q) && (rd_idx_q > prev_idx_q));
    after_e = (rd_data_q.side < prev_side_q) ||
              ((rd_data_q.side == prev_side_q) && after_p);
    if (cmd_i.mode_emit) begin
      qual   = flag_q[rd_idx_q] && (!prev_vld_q || after_e);
      better = !best_vld_q || (rd_data_q.side > best_side_q) ||
               ((rd_data_q.side == best_side_q) && (rd_data_q.prio > best_prio_q));
    end else begin
      qual   = rd_data_q.vis && (!prev_vld_q || after_p);
      better = !best_vld_q || (rd_data_q.prio > best_prio_q);
    end
  end

  // Budget and placement arithmetic
  assign sq        = 10'(best_side_q) * 10'(best_side_q);
  assign total_sum = total_q + 17'(sq);
  assign w_c       = (width_q == 9'd0) ? 9'd1 : ((width_q > 9'd256) ? 9'd256 : width_q);
  assign h_c       = (height_q == 9'd0) ? 9'd1 : ((height_q > 9'd256) ? 9'd256 : height_q);
  assign prod      = 18'(w_c) * 18'(h_c);
  assign emitted   = (admit_q > CntW'(EmitCap)) ? CntW'(EmitCap) : admit_q;
  assign emit_last = (CntW'(emit_q) + CntW'(1)) == emitted;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= DimReset;
      height_q   <= DimReset;
      cnt_q      <= '0;
      first_q    <= '0;
      scan_q     <= '0;
      rd_vld_q   <= 1'b0;
      best_vld_q <= 1'b0;
      prev_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegWidth:  width_q  <= cfg_wdata_i;
          RegHeight: height_q <= cfg_wdata_i;
          default:   ;
        endcase
      end
      if (cmd_i.load && (cnt_q == '0)) first_q <= in_data_i.light_id;
      if (cmd_i.finish) begin
        cnt_q <= '0;
      end else if (cmd_i.load && (cnt_q < CntW'(MaxCandidates))) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (cmd_i.scan_clr) begin
        scan_q <= '0;
      end else if (rd_en) begin
        scan_q <= scan_q + CntW'(1);
      end
      rd_vld_q <= rd_en;
      if (cmd_i.scan_clr) begin
        best_vld_q <= 1'b0;
      end else if (rd_vld_q && qual && better) begin
        best_vld_q <= 1'b1;
      end
      if (cmd_i.sel_init || cmd_i.emit_init) begin
        prev_vld_q <= 1'b0;
      end else if (cmd_i.admit || cmd_i.emit_out) begin
        prev_vld_q <= 1'b1;
      end
      if (cmd_i.emit_out || cmd_i.dflt_out) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (!cmd_i.scan_clr && rd_vld_q && qual && better) begin
      best_idx_q  <= rd_idx_q;
      best_id_q   <= rd_data_q.id;
      best_prio_q <= rd_data_q.prio;
      best_side_q <= rd_data_q.side;
    end
    if (cmd_i.admit || cmd_i.emit_out) begin
      prev_idx_q  <= best_idx_q;
      prev_prio_q <= best_prio_q;
      prev_side_q <= best_side_q;
    end
    if (cmd_i.sel_init) begin
      flag_q   <= '0;
      total_q  <= '0;
      admit_q  <= '0;
      budget_q <= prod[16:0];
    end else if (cmd_i.admit) begin
      flag_q[best_idx_q] <= 1'b1;
      total_q <= total_sum;
      admit_q <= admit_q + CntW'(1);
    end
    if (cmd_i.emit_init) begin
      emit_q <= '0;
      zidx_q <= '0;
    end else if (cmd_i.emit_out) begin
      emit_q <= emit_q + EmitW'(1);
      zidx_q <= total_sum - total_q + zidx_q;
    end
    if (cmd_i.emit_out) begin
      out_q.light_id_res <= best_id_q;
      for (int b = 0; b < 8; b++) begin
        out_q.atlas_x[b] <= zidx_q[2*b];
        out_q.atlas_y[b] <= zidx_q[2*b+1];
      end
      out_q.side_blocks <= best_side_q;
      out_q.last_res    <= emit_last;
    end else if (cmd_i.dflt_out) begin
      out_q.light_id_res <= first_q;
      out_q.atlas_x      <= '0;
      out_q.atlas_y      <= '0;
      out_q.side_blocks  <= 5'd1;
      out_q.last_res     <= 1'b1;
    end
  end

  // Status back to the controller
  always_comb begin
    status_o.scan_done  = (scan_q == cnt_q) && !rd_vld_q;
    status_o.best_vld   = best_vld_q;
    status_o.fits       = total_sum <= budget_q;
    status_o.any_sel    = prev_vld_q;
    status_o.admit_zero = admit_q == '0;
    status_o.emit_last  = emit_last;
    status_o.out_free   = !out_vld_q || !out_stall_i;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

>>> hdl/saa_ctrl.sv
module saa_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  output logic             in_stall_o,
  input  saa_pkg::status_t status_i,
  output saa_pkg::cmd_t    cmd_o
);
  import saa_pkg::*;

  localparam logic [2:0] SLoad     = 3'd0;
  localparam logic [2:0] SSelScan  = 3'd1;
  localparam logic [2:0] SSelChk   = 3'd2;
  localparam logic [2:0] SEmitScan = 3'd3;
  localparam logic [2:0] SEmitOut  = 3'd4;
  localparam logic [2:0] SDfltOut  = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_stall_o = state_q != SLoad;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      SLoad: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            cmd_o.sel_init = 1'b1;
            cmd_o.scan_clr = 1'b1;
            state_d        = SSelScan;
          end
        end
      end
      SSelScan: begin
        cmd_o.scan_run = 1'b1;
        if (status_i.scan_done) state_d = SSelChk;
      end
      SSelChk: begin
        // no visible light at all gives the default placement; a visible
        // light that does not fit leaves the run with no placement
        priority if (status_i.best_vld && status_i.fits) begin
          cmd_o.admit    = 1'b1;
          cmd_o.scan_clr = 1'b1;
          state_d        = SSelScan;
        end else if (!status_i.any_sel && !status_i.best_vld) begin
          state_d = SDfltOut;
        end else if (status_i.admit_zero) begin
          cmd_o.finish = 1'b1;
          state_d      = SLoad;
        end else begin
          cmd_o.emit_init = 1'b1;
          cmd_o.scan_clr  = 1'b1;
          state_d         = SEmitScan;
        end
      end
      SEmitScan: begin
        cmd_o.scan_run  = 1'b1;
        cmd_o.mode_emit = 1'b1;
        if (status_i.scan_done) state_d = SEmitOut;
      end
      SEmitOut: begin
        if (status_i.out_free) begin
          cmd_o.emit_out = 1'b1;
          if (status_i.emit_last) begin
            cmd_o.finish = 1'b1;
            state_d      = SLoad;
          end else begin
            cmd_o.scan_clr = 1'b1;
            state_d        = SEmitScan;
          end
        end
      end
      SDfltOut: begin
        if (status_i.out_free) begin
          cmd_o.dflt_out = 1'b1;
          cmd_o.finish   = 1'b1;
          state_d        = SLoad;
        end
      end
      default: state_d = SLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SLoad;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
